@@ rtl/dpd_pkg.sv @@
`timescale 1ns / 1ps
package dpd_pkg;

    localparam int DELIM_LEN_DEF = 19;
    localparam int NAME_LEN      = 19;

    localparam logic [7:0] DELIM_TEXT [NAME_LEN] = '{
        8'h50, 8'h41, 8'h43, 8'h4B, 8'h45, 8'h54, 8'h5F, 8'h45, 8'h4E, 8'h44,
        8'h5F, 8'h4E, 8'h6F, 8'h74, 8'h69, 8'h66, 8'h69, 8'h65, 8'h72
    };

    // one entry of the front-to-back queue
    typedef struct packed {
        logic       close;   // delimiter completed on this byte
        logic [7:0] data;
    } t_cmd;

    // delimiter byte at a position; zero past the text
    function automatic logic [7:0] delim_at(input logic [6:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx < 7'(NAME_LEN)) begin
            b = DELIM_TEXT[idx[4:0]];
        end
        return b;
    endfunction

endpackage

@@ rtl/dpd_in_if.sv @@
`timescale 1ns / 1ps
interface dpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

@@ rtl/dpd_out_if.sv @@
`timescale 1ns / 1ps
interface dpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       empty_packet;

    modport source (output valid, output out_byte, output last, output empty_packet,
                    input ready);
    modport sink   (input valid, input out_byte, input last, input empty_packet,
                    output ready);
endinterface

@@ rtl/dpd_front.sv @@
`timescale 1ns / 1ps
module dpd_front #(
    parameter int DELIM_LEN = dpd_pkg::DELIM_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    output logic          o_ready,
    output logic          o_push,
    output dpd_pkg::t_cmd o_cmd,
    input  logic          i_q_ready
);

    localparam int MW = $clog2(DELIM_LEN + 1);

    logic [MW-1:0] r_match_index;
    logic [MW-1:0] n_match_index;
    logic [MW-1:0] idx_plus;
    logic          hit;
    logic          hit_first;
    logic          complete;
    logic          accept;

    assign accept    = i_valid && i_q_ready;
    assign hit       = (dpd_pkg::delim_at(7'(r_match_index)) == i_byte);
    assign hit_first = (dpd_pkg::delim_at(7'd0) == i_byte) && (DELIM_LEN > 1);
    assign idx_plus  = r_match_index + 1'b1;
    assign complete  = hit && (idx_plus == MW'(DELIM_LEN));

    always_comb begin
        n_match_index = r_match_index;
        if (accept) begin
            if (complete) begin
                n_match_index = '0;
            end else if (hit) begin
                n_match_index = idx_plus;
            end else begin
                // restart: the byte may open a new delimiter
                n_match_index = hit_first ? MW'(1) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_index <= '0;
        end else begin
            r_match_index <= n_match_index;
        end
    end

    assign o_ready     = i_q_ready;
    assign o_push      = i_valid;
    assign o_cmd.close = complete;
    assign o_cmd.data  = i_byte;

endmodule

@@ rtl/dpd_cmd_queue.sv @@
`timescale 1ns / 1ps
module dpd_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dpd_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output dpd_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    dpd_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

@@ rtl/dpd_back.sv @@
`timescale 1ns / 1ps
module dpd_back #(
    parameter int DELIM_LEN = dpd_pkg::DELIM_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  dpd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_last,
    output logic          o_empty
);

    localparam int HOLD = DELIM_LEN - 1;
    localparam int CW   = (DELIM_LEN > 1) ? $clog2(DELIM_LEN) : 1;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [7:0]    r_pending;
    logic [7:0]    n_pending;
    logic          r_pending_valid;
    logic          n_pending_valid;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [7:0]    r_out_byte;
    logic [7:0]    n_out_byte;
    logic          r_out_last;
    logic          n_out_last;
    logic          r_out_empty;
    logic          n_out_empty;
    logic          pop;
    logic          shift;
    logic          full;
    logic [7:0]    leaving;

    assign pop   = i_q_valid && (!r_out_valid || i_ready);
    assign o_pop = pop;
    assign shift = pop && !i_cmd.close;
    assign full  = (r_count == CW'(HOLD));

    generate
        if (HOLD == 0) begin : g_no_line
            assign leaving = i_cmd.data;
        end else begin : g_line
            // newest at tap 0, oldest of a full line at the last tap
            logic [7:0] r_hold [HOLD];
            always_ff @(posedge i_clk) begin
                if (shift) begin
                    r_hold[0] <= i_cmd.data;
                    for (int i = 1; i < HOLD; i++) begin
                        r_hold[i] <= r_hold[i-1];
                    end
                end
            end
            assign leaving = r_hold[HOLD-1];
        end
    endgenerate

    always_comb begin
        n_count         = r_count;
        n_pending       = r_pending;
        n_pending_valid = r_pending_valid;
        n_out_valid     = r_out_valid && !i_ready;
        n_out_byte      = r_out_byte;
        n_out_last      = r_out_last;
        n_out_empty     = r_out_empty;
        if (pop) begin
            if (i_cmd.close) begin
                n_out_valid     = 1'b1;
                n_out_byte      = r_pending_valid ? r_pending : 8'h00;
                n_out_last      = r_pending_valid;
                n_out_empty     = !r_pending_valid;
                n_count         = '0;
                n_pending_valid = 1'b0;
            end else if (full) begin
                n_out_valid     = r_pending_valid;
                n_out_byte      = r_pending;
                n_out_last      = 1'b0;
                n_out_empty     = 1'b0;
                n_pending       = leaving;
                n_pending_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
                n_count     = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pending   <= n_pending;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count         <= '0;
            r_pending_valid <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_count         <= n_count;
            r_pending_valid <= n_pending_valid;
            r_out_valid     <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;
    assign o_empty = r_out_empty;

    a_close_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_cmd.close) |=> (r_out_valid && (r_out_last != r_out_empty)
                                  && !r_pending_valid && (r_count == '0)))
        else $error("packet close did not yield a closing beat");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(HOLD))
        else $error("hold line count overflow");

    a_pending_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending_valid |-> full)
        else $error("pending byte without a full hold line");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out_byte)))
        else $error("stalled result overwritten");

endmodule

@@ rtl/delimiter_packet_deframer.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Beat payload                      Handshake
// i_in      in   in_byte[7:0]                      valid / ready
// o_out     out  out_byte[7:0], last, empty_packet valid / ready
//
// One byte per cycle sustained while o_out accepts; a byte is matched against
// the delimiter as it is accepted, queued (2 entries), then applied to the hold
// line and pending register, one queue entry per cycle; result beats are then
// registered. Output stalls back up through the queue to i_in.ready.
// Synchronous active-low reset clears match index, fill count and queue.
module delimiter_packet_deframer #(
    parameter int DELIM_LEN = dpd_pkg::DELIM_LEN_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dpd_in_if.sink    i_in,
    dpd_out_if.source o_out
);

    logic          f_push;
    dpd_pkg::t_cmd f_cmd;
    logic          q_ready;
    logic          q_valid;
    dpd_pkg::t_cmd q_cmd;
    logic          b_pop;

    dpd_front #(.DELIM_LEN(DELIM_LEN)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_byte    (i_in.in_byte),
        .o_ready   (i_in.ready),
        .o_push    (f_push),
        .o_cmd     (f_cmd),
        .i_q_ready (q_ready)
    );

    dpd_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (b_pop)
    );

    dpd_back #(.DELIM_LEN(DELIM_LEN)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (b_pop),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_byte    (o_out.out_byte),
        .o_last    (o_out.last),
        .o_empty   (o_out.empty_packet)
    );

endmodule
